@@ src/bism_pkg.sv @@
// Shared types and constants for the bounded integer set block.
// No dependencies; every other file of the block uses this package.
package bism_pkg;

  localparam int CAPACITY_DEF = 256;

  // Field widths fixed by the interface
  localparam int VAL_W     = 16;
  localparam int CNT_OUT_W = 9;
  localparam int CFG_IDX_W = 1;

  // Encoder tree: groups of 16 lanes per level
  localparam int GRP   = 16;
  localparam int GRP_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

  localparam logic [VAL_W-1:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [VAL_W-1:0] RANGE_HIGH_RST = 16'd255;

  // Operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_RANGE   = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_BAD_CFG = 2'd3;

  // Per-request result data carried down the encoder pipeline
  typedef struct packed {
    status_t              status;
    logic                 present;
    logic [CNT_OUT_W-1:0] member_count;
  } meta_t;

endpackage

@@ src/bism_if.sv @@
// Valid/ready channel interfaces for request and result streams.
// Depends on bism_pkg for field widths and the status type.
interface bism_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [bism_pkg::VAL_W-1:0]   value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface bism_out_if;
  logic                                  valid;
  logic                                  ready;
  bism_pkg::status_t                     status;
  logic                                  was_present;
  logic [bism_pkg::CNT_OUT_W-1:0]        member_count;
  logic signed [bism_pkg::VAL_W-1:0]     min_value;
  logic signed [bism_pkg::VAL_W-1:0]     max_value;

  modport source (output valid, status, was_present, member_count, min_value, max_value,
                  input ready);
  modport sink   (input valid, status, was_present, member_count, min_value, max_value,
                  output ready);
endinterface

@@ src/bounded_integer_set_min_max_top.sv @@
// Top level of the bounded integer set with min/max tracking.
// Depends on bism_pkg, bism_if, bism_update, bism_leaf, bism_node, bism_out.
//
// Usage:
//   in_req  : insert (mode 0) or delete (mode 1) one signed 16-bit value.
//   out_res : one result per request: status, was_present, member count,
//             smallest and largest member (range_low-1 / range_high+1 if empty or range unusable).
//   cfg_*   : write range_low (index 0) or range_high (index 1); any write
//             empties the set. Write only while no request is in flight.
// Timing:
//   One request per cycle unless the pipeline stalls (see Stall). A result passes
//   through the bitmap update, 16-bit group encode, group merge and result
//   registers in order. The encoder depth is fixed by the three 16-way tree levels.
// Reset:
//   Synchronous, active low. Set empty, count zero, range [0, 255].
// Stall:
//   Each stage holds while the stage after it is full and stalled; in_req.ready
//   drops only once all four stages are full behind a stalled out_res.
module bounded_integer_set_min_max_top #(
  parameter int CAPACITY = bism_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  bism_in_if.sink                              in_req,
  bism_out_if.source                           out_res,
  input  logic                                 cfg_we,
  input  logic [bism_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bism_pkg::VAL_W-1:0]           cfg_wdata
);
  import bism_pkg::*;

  localparam int NG1 = (CAPACITY + GRP - 1) / GRP;  // leaf groups
  localparam int NG2 = (NG1 + GRP - 1) / GRP;       // merged groups, at most 16 while CAPACITY <= 4096

  // Range registers
  logic signed [VAL_W-1:0] range_low_r, range_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        CFG_RANGE_HIGH: range_high_r <= cfg_wdata;
      endcase
    end
  end

  // Pipeline advance chain, back from the result register
  logic upd_v, l1_v, l2_v;
  logic adv_out, adv_l2, adv_l1, adv_upd;

  assign adv_out      = !out_res.valid || out_res.ready;
  assign adv_l2       = !l2_v  || adv_out;
  assign adv_l1       = !l1_v  || adv_l2;
  assign adv_upd      = !upd_v || adv_l1;
  assign in_req.ready = adv_upd;

  // Stage 1: bitmap update
  meta_t               upd_meta;
  logic [CAPACITY-1:0] bitmap;

  bism_update #(.CAPACITY(CAPACITY)) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (cfg_we),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .load       (adv_upd),
    .in_valid   (in_req.valid),
    .mode       (in_req.mode),
    .value      (in_req.value),
    .v_r        (upd_v),
    .meta_r     (upd_meta),
    .bitmap_r   (bitmap)
  );

  // Stage 2: per-group first/last bit, sampled from the post-update bitmap
  meta_t                    l1_meta;
  logic [NG1-1:0]           l1_any;
  logic [NG1-1:0][GRP_W-1:0] l1_first, l1_last;

  bism_leaf #(.NG(NG1)) u_leaf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv_l1),
    .in_valid (upd_v),
    .meta     (upd_meta),
    .bits     ((NG1*GRP)'(bitmap)),
    .v_r      (l1_v),
    .meta_r   (l1_meta),
    .any_r    (l1_any),
    .first_r  (l1_first),
    .last_r   (l1_last)
  );

  // Stage 3: merge groups of 16
  meta_t                       l2_meta;
  logic [NG2-1:0]              l2_any;
  logic [NG2-1:0][2*GRP_W-1:0] l2_first, l2_last;

  bism_node #(.NGI(NG1), .IW(GRP_W)) u_node (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv_l2),
    .in_valid (l1_v),
    .meta     (l1_meta),
    .any      (l1_any),
    .first    (l1_first),
    .last     (l1_last),
    .v_r      (l2_v),
    .meta_r   (l2_meta),
    .any_r    (l2_any),
    .first_r  (l2_first),
    .last_r   (l2_last)
  );

  // Stage 4: final merge, min/max and result register
  bism_out #(.NG(NG2), .IW(2*GRP_W)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv_out),
    .in_valid   (l2_v),
    .meta       (l2_meta),
    .any        (l2_any),
    .first      (l2_first),
    .last       (l2_last),
    .range_low  (range_low_r),
    .range_high (range_high_r),
    .out_res    (out_res)
  );

  a_bad_cfg_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status == ST_BAD_CFG) |-> !out_res.was_present)
    else $error("bad config result flags a member");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status != ST_BAD_CFG && out_res.member_count != '0)
      |-> (out_res.min_value <= out_res.max_value))
    else $error("non-empty set reports min above max");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> upd_v)
    else $error("accepted request lost at update stage");

endmodule

@@ src/bism_update.sv @@
// Membership bitmap and count: applies one insert/delete per cycle while load is high.
// Depends on bism_pkg.
module bism_update #(
  parameter int CAPACITY = bism_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clr,
  input  logic signed [bism_pkg::VAL_W-1:0] range_low,
  input  logic signed [bism_pkg::VAL_W-1:0] range_high,
  input  logic                              load,
  input  logic                              in_valid,
  input  logic                              mode,
  input  logic signed [bism_pkg::VAL_W-1:0] value,
  output logic                              v_r,
  output bism_pkg::meta_t                   meta_r,
  output logic [CAPACITY-1:0]               bitmap_r
);
  import bism_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = VAL_W + 2;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CAPACITY-1:0]     bitmap_nxt;
  logic signed [EXT_W-1:0] low_x, high_x, val_x, span_m1, off;
  logic [IDX_W-1:0]        idx;
  logic                    good, inrange, present, take;
  status_t                 status;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
  meta_t                   meta_nxt;

  assign take   = load & in_valid;
  assign low_x  = {{2{range_low[VAL_W-1]}}, range_low};
  assign high_x = {{2{range_high[VAL_W-1]}}, range_high};
  assign val_x  = {{2{value[VAL_W-1]}}, value};

  // range must be non-degenerate and fit the bitmap
  assign span_m1 = high_x - low_x;
  assign good    = (low_x < high_x) && (span_m1 < $signed(EXT_W'(CAPACITY)));
  assign inrange = (val_x >= low_x) && (val_x <= high_x);
  assign off     = val_x - low_x;
  assign idx     = off[IDX_W-1:0];
  assign present = good && inrange && bitmap_r[idx];

  always_comb begin
    bitmap_nxt = bitmap_r;
    count_nxt  = count_r;
    status     = ST_OK;
    priority if (!good) begin
      status = ST_BAD_CFG;
    end else if (mode == MODE_INSERT) begin
      priority if (!inrange) begin
        status = ST_RANGE;
      end else if (!present) begin
        bitmap_nxt[idx] = 1'b1;
        count_nxt       = count_r + 1'b1;
      end else begin
        // duplicate: set unchanged
        status = ST_OK;
      end
    end else begin
      priority if (count_r == '0) begin
        status = ST_EMPTY;
      end else if (present) begin
        bitmap_nxt[idx] = 1'b0;
        count_nxt       = count_r - 1'b1;
      end else begin
        // absent or out-of-range value: count holds
        status = ST_OK;
      end
    end
  end

  assign cnt_ext               = {{CNT_OUT_W{1'b0}}, count_nxt};
  assign meta_nxt.status       = status;
  assign meta_nxt.present      = present;
  assign meta_nxt.member_count = cnt_ext[CNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r <= '0;
      count_r  <= '0;
      v_r      <= 1'b0;
    end else begin
      if (clr) begin
        bitmap_r <= '0;
        count_r  <= '0;
      end else if (take) begin
        bitmap_r <= bitmap_nxt;
        count_r  <= count_nxt;
      end
      if (load) begin
        v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r <= meta_nxt;
    end
  end

  a_count_matches_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(bitmap_r) == count_r)
    else $error("member count disagrees with bitmap population");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (count_r == '0) && (bitmap_r == '0))
    else $error("config write did not empty the set");

  a_bad_cfg_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !good && !clr) |=> $stable(bitmap_r) && $stable(count_r))
    else $error("set changed under bad config");

endmodule

@@ src/bism_leaf.sv @@
// First level of the min/max encoder: first/last set bit in each 16-bit group.
// Depends on bism_pkg.
module bism_leaf #(
  parameter int NG = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic                                  in_valid,
  input  bism_pkg::meta_t                       meta,
  input  logic [NG*bism_pkg::GRP-1:0]           bits,
  output logic                                  v_r,
  output bism_pkg::meta_t                       meta_r,
  output logic [NG-1:0]                         any_r,
  output logic [NG-1:0][bism_pkg::GRP_W-1:0]    first_r,
  output logic [NG-1:0][bism_pkg::GRP_W-1:0]    last_r
);
  import bism_pkg::*;

  logic [NG-1:0]            any_nxt;
  logic [NG-1:0][GRP_W-1:0] first_nxt, last_nxt;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      any_nxt[g]   = |bits[g*GRP +: GRP];
      first_nxt[g] = '0;
      last_nxt[g]  = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (bits[g*GRP + k]) first_nxt[g] = GRP_W'(k);
      end
      for (int k = 0; k < GRP; k++) begin
        if (bits[g*GRP + k]) last_nxt[g] = GRP_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r  <= meta;
      any_r   <= any_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ src/bism_node.sv @@
// Inner level of the min/max encoder: merges groups of 16 lanes into one.
// Depends on bism_pkg.
module bism_node #(
  parameter int NGI = 16,
  parameter int IW  = 4
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    load,
  input  logic                                                    in_valid,
  input  bism_pkg::meta_t                                         meta,
  input  logic [NGI-1:0]                                          any,
  input  logic [NGI-1:0][IW-1:0]                                  first,
  input  logic [NGI-1:0][IW-1:0]                                  last,
  output logic                                                    v_r,
  output bism_pkg::meta_t                                         meta_r,
  output logic [(NGI+bism_pkg::GRP-1)/bism_pkg::GRP-1:0]          any_r,
  output logic [(NGI+bism_pkg::GRP-1)/bism_pkg::GRP-1:0][IW+bism_pkg::GRP_W-1:0] first_r,
  output logic [(NGI+bism_pkg::GRP-1)/bism_pkg::GRP-1:0][IW+bism_pkg::GRP_W-1:0] last_r
);
  import bism_pkg::*;

  localparam int NGO = (NGI + GRP - 1) / GRP;
  localparam int OW  = IW + GRP_W;

  logic [NGO*GRP-1:0]           any_p;
  logic [NGO*GRP-1:0][IW-1:0]   first_p, last_p;
  logic [NGO-1:0]               any_nxt;
  logic [NGO-1:0][OW-1:0]       first_nxt, last_nxt;

  assign any_p = (NGO*GRP)'(any);

  always_comb begin
    first_p = '0;
    last_p  = '0;
    for (int i = 0; i < NGI; i++) begin
      first_p[i] = first[i];
      last_p[i]  = last[i];
    end
  end

  always_comb begin
    for (int g = 0; g < NGO; g++) begin
      any_nxt[g]   = |any_p[g*GRP +: GRP];
      first_nxt[g] = '0;
      last_nxt[g]  = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (any_p[g*GRP + k]) first_nxt[g] = {GRP_W'(k), first_p[g*GRP + k]};
      end
      for (int k = 0; k < GRP; k++) begin
        if (any_p[g*GRP + k]) last_nxt[g] = {GRP_W'(k), last_p[g*GRP + k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r  <= meta;
      any_r   <= any_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ src/bism_out.sv @@
// Final encoder level and result register: forms min/max and drives the result channel.
// Depends on bism_pkg and bism_out_if.
module bism_out #(
  parameter int NG = 1,
  parameter int IW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic                              in_valid,
  input  bism_pkg::meta_t                   meta,
  input  logic [NG-1:0]                     any,
  input  logic [NG-1:0][IW-1:0]             first,
  input  logic [NG-1:0][IW-1:0]             last,
  input  logic signed [bism_pkg::VAL_W-1:0] range_low,
  input  logic signed [bism_pkg::VAL_W-1:0] range_high,
  bism_out_if.source                        out_res
);
  import bism_pkg::*;

  localparam int XW = IW + GRP_W;

  logic [XW-1:0]          fidx, lidx;
  logic                   empty;
  logic signed [VAL_W-1:0] min_nxt, max_nxt;
  logic                   v_r;
  meta_t                  meta_r;
  logic signed [VAL_W-1:0] min_r, max_r;

  always_comb begin
    fidx = '0;
    lidx = '0;
    for (int k = NG - 1; k >= 0; k--) begin
      if (any[k]) fidx = {GRP_W'(k), first[k]};
    end
    for (int k = 0; k < NG; k++) begin
      if (any[k]) lidx = {GRP_W'(k), last[k]};
    end
  end

  // empty set (or bad range) reports the bounds just outside the range
  assign empty   = !(|any) || (meta.status == ST_BAD_CFG);
  assign min_nxt = empty ? range_low - 16'sd1  : range_low + VAL_W'(fidx);
  assign max_nxt = empty ? range_high + 16'sd1 : range_low + VAL_W'(lidx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r <= meta;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
    end
  end

  assign out_res.valid        = v_r;
  assign out_res.status       = meta_r.status;
  assign out_res.was_present  = meta_r.present;
  assign out_res.member_count = meta_r.member_count;
  assign out_res.min_value    = min_r;
  assign out_res.max_value    = max_r;

endmodule

@@ tb/bounded_integer_set_min_max_top_tb.sv @@
// Self-checking testbench for bounded_integer_set_min_max_top.
// Depends on bism_pkg and the bism_in_if / bism_out_if channel interfaces.
// Drives insert/delete requests, predicts each result and checks it in order.
module bounded_integer_set_min_max_top_tb;
  import bism_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int STALL_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int MAX_SHOWN  = 10;

  // One request as queued for the driver
  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
  } set_req_t;

  // One result, field order as on the result channel
  typedef struct packed {
    status_t                 status;
    logic                    present;
    logic [CNT_OUT_W-1:0]    member_count;
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
  } set_reply_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]   cfg_wdata;

  bism_in_if  in_ch ();
  bism_out_if out_ch ();

  bounded_integer_set_min_max_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_ch),
    .out_res  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: bitmap, member count and the configured range.
  // Mirrors the block after every config write and accepted request.
  // ---------------------------------------------------------------------------
  bit         set_bits [CAP];
  int         set_count;
  int         range_lo;
  int         range_hi;

  set_reply_t expected_replies [$];
  set_req_t   pending_reqs [$];
  int         err_cnt;
  int         cyc;
  int         idle_cycles;
  bit         calm;
  set_req_t   drv_req;
  set_reply_t got_reply;
  set_reply_t want_reply;

  function automatic void empty_set();
    foreach (set_bits[k]) set_bits[k] = 1'b0;
    set_count = 0;
  endfunction

  // Applies one request to the predicted set and returns the result it gives.
  function automatic set_reply_t next_set_reply(logic mode, logic signed [VAL_W-1:0] v);
    set_reply_t r;
    int         span;
    int         idx;
    int         minv;
    int         maxv;
    bit         inr;
    bit         hit;
    bit         found_lo;
    bit         found_hi;
    span     = range_hi - range_lo + 1;
    minv     = range_lo - 1;
    maxv     = range_hi + 1;
    r.status  = ST_OK;
    r.present = 1'b0;
    found_lo  = 1'b0;
    found_hi  = 1'b0;
    if (!(range_lo < range_hi && span <= CAP)) begin
      // Unusable range: report empty bounds, touch nothing
      r.status = ST_BAD_CFG;
    end else begin
      inr = (int'(v) >= range_lo) && (int'(v) <= range_hi);
      idx = inr ? int'(v) - range_lo : 0;
      hit = inr && set_bits[idx];
      r.present = hit;
      if (mode == MODE_INSERT) begin
        if (!inr) begin
          r.status = ST_RANGE;
        end else if (!hit) begin
          set_bits[idx] = 1'b1;
          set_count++;
        end
      end else begin
        // Empty check wins over the range check on delete
        if (set_count == 0) begin
          r.status = ST_EMPTY;
        end else if (hit) begin
          set_bits[idx] = 1'b0;
          set_count--;
        end
      end
      for (int k = 0; k < span; k++) begin
        if (!found_lo && set_bits[k]) begin
          minv     = range_lo + k;
          found_lo = 1'b1;
        end
        if (!found_hi && set_bits[span-1-k]) begin
          maxv     = range_lo + span - 1 - k;
          found_hi = 1'b1;
        end
      end
    end
    r.member_count = set_count[CNT_OUT_W-1:0];
    r.min_value    = minv[VAL_W-1:0];   // empty bounds wrap to 16 bits
    r.max_value    = maxv[VAL_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stall windows: about 8 percent stall odds on each side, except for a calm
  // stretch early in the long default-range phase where both run flat out.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc  <= cyc + 1;
    calm <= (cyc >= 150) && (cyc < 650);
  end

  // Request driver: presents the next queued request once the current one is
  // taken (or none is up), with random bubbles between requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.mode  <= MODE_INSERT;
      in_ch.value <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        drv_req      = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.mode  <= drv_req.mode;
        in_ch.value <= drv_req.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: checks results against the oldest prediction, then tracks
  // config writes and newly accepted requests. Config writes happen only
  // while the pipe is drained, so they never share an edge with a request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      empty_set();
      range_lo = int'($signed(RANGE_LOW_RST));
      range_hi = int'($signed(RANGE_HIGH_RST));
      expected_replies.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_reply = {out_ch.status, out_ch.was_present, out_ch.member_count,
                     out_ch.min_value, out_ch.max_value};
        if (expected_replies.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("[%0d] unexpected result: st=%0d pres=%0d cnt=%0d min=%0d max=%0d",
                     cyc, got_reply.status, got_reply.present, got_reply.member_count,
                     got_reply.min_value, got_reply.max_value);
        end else begin
          want_reply = expected_replies.pop_front();
          if (got_reply !== want_reply) begin
            err_cnt++;
            if (err_cnt <= MAX_SHOWN)
              $display("[%0d] result mismatch: exp st=%0d pres=%0d cnt=%0d min=%0d max=%0d",
                       cyc, want_reply.status, want_reply.present, want_reply.member_count,
                       want_reply.min_value, want_reply.max_value,
                       " / got st=%0d pres=%0d cnt=%0d min=%0d max=%0d",
                       got_reply.status, got_reply.present, got_reply.member_count,
                       got_reply.min_value, got_reply.max_value);
          end
        end
      end
      // Any register write re-bases the bitmap, so the set empties
      if (cfg_we) begin
        if (cfg_index == CFG_RANGE_LOW) range_lo = int'($signed(cfg_wdata));
        else                            range_hi = int'($signed(cfg_wdata));
        empty_set();
      end
      if (in_ch.valid && in_ch.ready)
        expected_replies.push_back(next_set_reply(in_ch.mode, in_ch.value));
    end
  end

  // Watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side. A shadow of the set contents steers random requests so
  // the set really fills up and drains, instead of hovering near empty.
  // ---------------------------------------------------------------------------
  bit g_bits [CAP];
  int g_cnt;
  int g_lo;
  int g_span;
  bit g_good;
  bit g_fill;

  task automatic queue_req(logic mode, logic signed [VAL_W-1:0] v);
    int idx;
    set_req_t r;
    r.mode  = mode;
    r.value = v;
    if (g_good && int'(v) >= g_lo && int'(v) < g_lo + g_span) begin
      idx = int'(v) - g_lo;
      if (mode == MODE_INSERT && !g_bits[idx]) begin
        g_bits[idx] = 1'b1;
        g_cnt++;
      end else if (mode == MODE_DELETE && g_bits[idx]) begin
        g_bits[idx] = 1'b0;
        g_cnt--;
      end
    end
    pending_reqs.push_back(r);
  endtask

  // Random slot holding (want=1) or lacking (want=0) a member, -1 if none.
  function automatic int find_slot(bit want);
    int start;
    int j;
    start = $urandom_range(0, g_span - 1);
    for (int k = 0; k < g_span; k++) begin
      j = (start + k) % g_span;
      if (g_bits[j] == want) return j;
    end
    return -1;
  endfunction

  task automatic drain_pipe();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_replies.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_range(int lo, int hi);
    drain_pipe();
    write_reg(CFG_RANGE_LOW, lo[VAL_W-1:0]);
    write_reg(CFG_RANGE_HIGH, hi[VAL_W-1:0]);
    foreach (g_bits[k]) g_bits[k] = 1'b0;
    g_cnt  = 0;
    g_lo   = lo;
    g_span = hi - lo + 1;
    g_good = (lo < hi) && (g_span <= CAP);
    g_fill = 1'b1;
    @(negedge clk);
  endtask

  // Mostly well-formed traffic: in fill mode mostly inserts of absent values,
  // in drain mode mostly deletes of members; the mode flips at full and empty.
  task automatic random_reqs(int n);
    logic                    mode;
    logic signed [VAL_W-1:0] v;
    int                      roll;
    int                      idx;
    for (int i = 0; i < n; i++) begin
      if (g_good) begin
        if (g_cnt == g_span) g_fill = 1'b0;
        else if (g_cnt == 0) g_fill = 1'b1;
      end
      if ($urandom_range(0, 99) < 92) mode = g_fill ? MODE_INSERT : MODE_DELETE;
      else                            mode = g_fill ? MODE_DELETE : MODE_INSERT;
      roll = $urandom_range(0, 99);
      if (!g_good || roll < 6) begin
        v = VAL_W'($urandom);
      end else if (roll < 12) begin
        // just inside and just outside the range
        case ($urandom_range(0, 3))
          0:       v = VAL_W'(g_lo - 1);
          1:       v = VAL_W'(g_lo);
          2:       v = VAL_W'(g_lo + g_span - 1);
          default: v = VAL_W'(g_lo + g_span);
        endcase
      end else begin
        idx = ($urandom_range(0, 99) < 90) ? find_slot(mode == MODE_DELETE) : -1;
        if (idx < 0) idx = $urandom_range(0, g_span - 1);
        v = VAL_W'(g_lo + idx);
      end
      queue_req(mode, v);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_RANGE_LOW;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_INSERT;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    err_cnt      = 0;
    cyc          = 0;
    idle_cycles  = 0;
    calm         = 1'b0;
    foreach (g_bits[k]) g_bits[k] = 1'b0;
    g_cnt  = 0;
    g_lo   = 0;
    g_span = CAP;
    g_good = 1'b1;
    g_fill = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests on the reset range [0, 255]
    queue_req(MODE_DELETE, 16'sd7);        // delete from empty set
    queue_req(MODE_DELETE, -16'sd32768);   // empty wins over out of range
    queue_req(MODE_INSERT, 16'sd0);        // range edges
    queue_req(MODE_INSERT, 16'sd255);
    queue_req(MODE_INSERT, 16'sd128);
    queue_req(MODE_INSERT, 16'sd128);      // duplicate
    queue_req(MODE_INSERT, 16'sd256);      // out of range, both sides
    queue_req(MODE_INSERT, -16'sd1);
    queue_req(MODE_INSERT, -16'sd32768);   // field extremes
    queue_req(MODE_INSERT, 16'sd32767);
    queue_req(MODE_INSERT, 16'sh5555);
    queue_req(MODE_INSERT, 16'shAAAA);
    queue_req(MODE_DELETE, 16'sd300);      // out-of-range delete on non-empty set
    queue_req(MODE_DELETE, 16'sd5);        // absent value: count must hold
    queue_req(MODE_DELETE, 16'sd128);
    queue_req(MODE_DELETE, 16'sd0);
    queue_req(MODE_DELETE, 16'sd255);      // set now empty
    queue_req(MODE_DELETE, 16'sd255);

    // Long run on the reset range, deep enough to fill all 256 slots
    random_reqs(510);

    // Full-capacity windows at both ends of the value space
    set_range(-32767, -32512);
    random_reqs(100);
    set_range(32511, 32766);
    random_reqs(100);

    // Small ranges, including the narrowest legal one
    set_range(-5, 5);
    random_reqs(120);
    set_range(10, 11);
    random_reqs(60);

    // Unusable ranges: equal bounds, reversed, one over capacity, near the full 16-bit span
    set_range(10, 10);
    random_reqs(5);
    set_range(20, -20);
    random_reqs(5);
    set_range(0, CAP);
    random_reqs(5);
    set_range(-32767, 32766);
    random_reqs(5);

    drain_pipe();
    repeat (8) @(posedge clk);  // catch any stray result
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
